// ===== sv/tlshp_pkg.sv =====
`timescale 1ns / 1ps

package tlshp_pkg;

    // Largest buffer the parser accepts, in bytes
    localparam int unsigned MAX_BUFFER = 16384;

    localparam int POS_W  = 15;
    localparam int BLEN_W = 15;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Handshake message types
    localparam logic [7:0] HS_HELLO = 8'd2;
    localparam logic [7:0] HS_CERT  = 8'd11;
    localparam logic [7:0] HS_KEYX  = 8'd12;
    localparam logic [7:0] HS_DONE  = 8'd14;

    localparam logic [23:0] HELLO_MIN_BODY = 24'd38;
    localparam logic [23:0] KEYX_MIN_BODY  = 24'd69;
    localparam logic [15:0] CURVE_P256     = 16'h0017;
    localparam logic [7:0]  CURVE_NAMED    = 8'd3;
    localparam logic [7:0]  POINT_LEN      = 8'd65;
    localparam logic [7:0]  POINT_UNCOMP   = 8'h04;
    localparam logic [15:0] SID_POS        = 16'd38;
    localparam logic [15:0] SUITE_BASE     = 16'd39;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_GO      = 2'd1,
        ST_FAIL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_RANDOM  = 2'd0,
        KIND_POINT_X = 2'd1,
        KIND_POINT_Y = 2'd2,
        KIND_FINAL   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PROG_NONE  = 3'd0,
        PROG_HELLO = 3'd1,
        PROG_CERT  = 3'd2,
        PROG_KEYX  = 3'd3,
        PROG_DONE  = 3'd4
    } prog_t;

    // Seen flags: bit0 hello, bit1 certificate, bit2 done, bit3 ecdhe
    typedef struct packed {
        logic ecdhe;
        logic done;
        logic cert;
        logic hello;
    } flags_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  byte_index;
        logic [7:0]  captured_byte;
        logic        success;
        logic [7:0]  message_type;
        prog_t       handshake_state;
        logic [15:0] protocol_version;
        logic [15:0] chosen_suite;
        flags_t      flags;
    } result_t;

endpackage

// ===== sv/tlshp_core.sv =====
`timescale 1ns / 1ps

// Per-byte parser state and decode; one byte per step, result is combinational.
module tlshp_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            step,
    input  logic [7:0]                      data_byte,
    input  logic [tlshp_pkg::BLEN_W-1:0]    buffer_length,
    input  logic                            last_byte,
    output logic                            res_valid,
    output tlshp_pkg::result_t              res
);

    logic [tlshp_pkg::POS_W-1:0] pos_reg;
    logic [7:0]                  type_reg, type_next;
    logic [23:0]                 body_reg, body_next;
    logic [7:0]                  sid_reg, sid_next;
    tlshp_pkg::status_t          status_reg, status_next;
    logic                        pco_reg, pco_next;
    logic [15:0]                 ver_reg, ver_next;
    logic [15:0]                 suite_reg, suite_next;
    tlshp_pkg::prog_t            prog_reg, prog_next;
    tlshp_pkg::flags_t           flags_reg, flags_next;

    logic [15:0]       pos16;
    logic              cap_valid;
    tlshp_pkg::kind_t  cap_kind;
    logic [4:0]        cap_idx;
    logic              ok;
    logic              len_bad;
    logic              size_bad;

    assign pos16 = {1'b0, pos_reg};

    // header length checks, evaluated on the fourth byte
    assign len_bad  = ({1'b0, body_next} + 25'd4) > {10'd0, buffer_length};
    assign size_bad = {2'b00, buffer_length} > 17'(tlshp_pkg::MAX_BUFFER);

    always_comb
    begin
        type_next   = (pos_reg == '0) ? data_byte : type_reg;
        body_next   = body_reg;
        if (pos_reg >= 15'd1 && pos_reg <= 15'd3)
        begin
            body_next = {body_reg[15:0], data_byte};
        end
        sid_next    = sid_reg;
        status_next = status_reg;
        pco_next    = pco_reg;
        ver_next    = ver_reg;
        suite_next  = suite_reg;
        cap_valid   = 1'b0;
        cap_kind    = tlshp_pkg::KIND_RANDOM;
        cap_idx     = '0;

        if (pos_reg == 15'd3)
        begin
            if (len_bad || size_bad)
            begin
                status_next = tlshp_pkg::ST_FAIL;
            end
            else if (type_reg == tlshp_pkg::HS_HELLO)
            begin
                status_next = (body_next < tlshp_pkg::HELLO_MIN_BODY) ?
                              tlshp_pkg::ST_FAIL : tlshp_pkg::ST_GO;
            end
            else if (type_reg == tlshp_pkg::HS_CERT || type_reg == tlshp_pkg::HS_DONE)
            begin
                status_next = tlshp_pkg::ST_GO;
            end
            else if (type_reg == tlshp_pkg::HS_KEYX)
            begin
                status_next = tlshp_pkg::ST_GO;
                pco_next    = (body_next >= tlshp_pkg::KEYX_MIN_BODY);
            end
            else
            begin
                status_next = tlshp_pkg::ST_FAIL;
            end
        end
        else if (status_reg == tlshp_pkg::ST_GO && type_reg == tlshp_pkg::HS_HELLO)
        begin
            if (pos_reg == 15'd4)
            begin
                ver_next = {data_byte, ver_reg[7:0]};
            end
            else if (pos_reg == 15'd5)
            begin
                ver_next = {ver_reg[15:8], data_byte};
            end
            else if (pos_reg >= 15'd6 && pos_reg < 15'd38)
            begin
                cap_valid = 1'b1;
                cap_kind  = tlshp_pkg::KIND_RANDOM;
                cap_idx   = 5'(pos_reg - 15'd6);
            end
            else if (pos16 == tlshp_pkg::SID_POS)
            begin
                sid_next = data_byte;
                // suite must fit inside the buffer
                if (tlshp_pkg::SUITE_BASE + 16'd2 + {8'd0, data_byte} >
                    {1'b0, buffer_length})
                begin
                    status_next = tlshp_pkg::ST_FAIL;
                end
            end
            else if (pos16 == tlshp_pkg::SUITE_BASE + {8'd0, sid_reg})
            begin
                suite_next = {data_byte, suite_reg[7:0]};
            end
            else if (pos16 == tlshp_pkg::SUITE_BASE + 16'd1 + {8'd0, sid_reg})
            begin
                suite_next = {suite_reg[15:8], data_byte};
            end
        end
        else if (status_reg == tlshp_pkg::ST_GO && type_reg == tlshp_pkg::HS_KEYX && pco_reg)
        begin
            if ((pos_reg == 15'd4 && data_byte != tlshp_pkg::CURVE_NAMED) ||
                (pos_reg == 15'd5 && data_byte != tlshp_pkg::CURVE_P256[15:8]) ||
                (pos_reg == 15'd6 && data_byte != tlshp_pkg::CURVE_P256[7:0]) ||
                (pos_reg == 15'd7 && data_byte != tlshp_pkg::POINT_LEN) ||
                (pos_reg == 15'd8 && data_byte != tlshp_pkg::POINT_UNCOMP))
            begin
                pco_next = 1'b0;
            end
            else if (pos_reg >= 15'd9 && pos_reg < 15'd41)
            begin
                cap_valid = 1'b1;
                cap_kind  = tlshp_pkg::KIND_POINT_X;
                cap_idx   = 5'(pos_reg - 15'd9);
            end
            else if (pos_reg >= 15'd41 && pos_reg < 15'd73)
            begin
                cap_valid = 1'b1;
                cap_kind  = tlshp_pkg::KIND_POINT_Y;
                cap_idx   = 5'(pos_reg - 15'd41);
            end
        end
    end

    // end-of-buffer verdict and kept state
    always_comb
    begin
        ok         = (status_next == tlshp_pkg::ST_GO);
        prog_next  = prog_reg;
        flags_next = flags_reg;
        if (ok)
        begin
            unique case (type_next)
                tlshp_pkg::HS_HELLO:
                begin
                    if (pos16 >= tlshp_pkg::SUITE_BASE + 16'd1 + {8'd0, sid_next})
                    begin
                        flags_next.hello = 1'b1;
                        prog_next        = tlshp_pkg::PROG_HELLO;
                    end
                    else
                    begin
                        ok = 1'b0;
                    end
                end
                tlshp_pkg::HS_CERT:
                begin
                    flags_next.cert = 1'b1;
                    prog_next       = tlshp_pkg::PROG_CERT;
                end
                tlshp_pkg::HS_KEYX:
                begin
                    prog_next = tlshp_pkg::PROG_KEYX;
                    if (pco_next && pos_reg >= 15'd72)
                    begin
                        flags_next.ecdhe = 1'b1;
                    end
                end
                default:
                begin
                    flags_next.done = 1'b1;
                    prog_next       = tlshp_pkg::PROG_DONE;
                end
            endcase
        end
    end

    always_comb
    begin
        res       = '0;
        res_valid = step && (last_byte || cap_valid);
        if (last_byte)
        begin
            res.kind             = tlshp_pkg::KIND_FINAL;
            res.byte_index       = cap_valid ? cap_idx : 5'd0;
            res.captured_byte    = cap_valid ? data_byte : 8'd0;
            res.success          = ok;
            res.message_type     = type_next;
            res.handshake_state  = prog_next;
            res.protocol_version = ver_next;
            res.chosen_suite     = suite_next;
            res.flags            = flags_next;
        end
        else
        begin
            res.kind          = cap_kind;
            res.byte_index    = cap_idx;
            res.captured_byte = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            type_reg   <= '0;
            body_reg   <= '0;
            sid_reg    <= '0;
            status_reg <= tlshp_pkg::ST_PENDING;
            pco_reg    <= 1'b0;
            ver_reg    <= '0;
            suite_reg  <= '0;
            prog_reg   <= tlshp_pkg::PROG_NONE;
            flags_reg  <= '0;
        end
        else if (step)
        begin
            ver_reg   <= ver_next;
            suite_reg <= suite_next;
            if (last_byte)
            begin
                pos_reg    <= '0;
                type_reg   <= '0;
                body_reg   <= '0;
                sid_reg    <= '0;
                status_reg <= tlshp_pkg::ST_PENDING;
                pco_reg    <= 1'b0;
                prog_reg   <= prog_next;
                flags_reg  <= flags_next;
            end
            else
            begin
                if (pos_reg != tlshp_pkg::POS_MAX)
                begin
                    pos_reg <= pos_reg + 15'd1;
                end
                type_reg   <= type_next;
                body_reg   <= body_next;
                sid_reg    <= sid_next;
                status_reg <= status_next;
                pco_reg    <= pco_next;
            end
        end
    end

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> pos_reg == '0 && status_reg == tlshp_pkg::ST_PENDING)
        else $error("message state not cleared after last byte");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_byte && pos_reg != tlshp_pkg::POS_MAX
        |=> pos_reg == $past(pos_reg) + 15'd1)
        else $error("byte position did not advance");

    a_header_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 15'd3 |-> status_reg == tlshp_pkg::ST_PENDING)
        else $error("status decided before header complete");

    a_capture_needs_go: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind != tlshp_pkg::KIND_FINAL |-> status_reg == tlshp_pkg::ST_GO)
        else $error("capture from a message not in progress");

    a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && last_byte) |=> $stable(flags_reg) && $stable(prog_reg))
        else $error("kept flags changed away from a last byte");

endmodule

// ===== sv/tls_server_handshake_parser.sv =====
`timescale 1ns / 1ps

// Streaming parser for one server-side TLS 1.2 handshake message per buffer.
// Each input word carries one payload byte and the buffer length; tlast marks
// the final byte. ServerHello random bytes and the ServerKeyExchange P-256
// point X/Y bytes come out as they pass (tuser = kind 0/1/2); the last byte
// of a buffer yields one final-status word (kind 3) with success, type, kept
// handshake state, version, cipher suite and seen flags. Throughput is one
// byte per clock unless m_axis_tready stalls the output: each byte is
// decoded combinationally between the input and output registers, the
// parser state being updated in the same cycle. Buffer lengths above
// 16384 bytes are rejected.
module tls_server_handshake_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // slave: [7:0] data_byte, [22:8] buffer_length, [23] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // master: [4:0] byte_index, [12:5] captured_byte, [13] success,
    // [21:14] message_type, [24:22] handshake_state, [40:25] protocol_version,
    // [56:41] chosen_suite, [57] hello_seen, [58] certificate_seen,
    // [59] done_seen, [60] ecdhe_agreed, [63:61] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    // [1:0] result_kind
    output logic [1:0]  m_axis_tuser
);

    // input stage
    logic                         in_valid_reg;
    logic [7:0]                   in_byte_reg;
    logic [tlshp_pkg::BLEN_W-1:0] in_blen_reg;
    logic                         in_last_reg;

    // output stage
    logic                 out_valid_reg;
    tlshp_pkg::result_t   out_res_reg;

    logic                 advance;
    logic                 core_valid;
    tlshp_pkg::result_t   core_res;

    // a byte moves on whenever the output slot is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_blen_reg <= s_axis_tdata[22:8];
            in_last_reg <= s_axis_tlast;
        end
    end

    tlshp_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .buffer_length (in_blen_reg),
        .last_byte     (in_last_reg),
        .res_valid     (core_valid),
        .res           (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= core_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_valid)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tdata  = {3'b000,
                            out_res_reg.flags.ecdhe,
                            out_res_reg.flags.done,
                            out_res_reg.flags.cert,
                            out_res_reg.flags.hello,
                            out_res_reg.chosen_suite,
                            out_res_reg.protocol_version,
                            out_res_reg.handshake_state,
                            out_res_reg.message_type,
                            out_res_reg.success,
                            out_res_reg.captured_byte,
                            out_res_reg.byte_index};

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_res_reg))
        else $error("pending result overwritten");

    a_advance_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> in_valid_reg && (!out_valid_reg || m_axis_tready))
        else $error("byte advanced into a full output stage");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
        && $stable(in_last_reg))
        else $error("stalled input byte lost");

endmodule
